>>> sv/wss_pkg.sv
// wss_pkg: shared types, widths and constants for the window statistics block.
// No dependencies; imported by every module under sv/.
package wss_pkg;

  // Sample and window
  localparam int SAMPLE_W = 12;
  localparam logic [SAMPLE_W-1:0] MID_CODE = 12'd2048;
  localparam int WLEN_W   = 13;
  localparam logic [WLEN_W-1:0] MAX_WIN = 13'd4096;
  localparam int CNT_W    = 13;
  localparam int RATE_W   = 20;

  // Accumulators
  localparam int SQ_W     = 35;
  localparam int SUM_W    = 24;
  localparam int CROSS_W  = 12;
  localparam logic [CROSS_W-1:0] CROSS_MAX = 12'd4095;

  // Result widths
  localparam int FREQ_W   = 19;
  localparam int PROD_W   = 32;

  // Shared divider
  localparam int DIVD_W    = 35;
  localparam int DIVS_W    = 14;
  localparam int DIV_CNT_W = $clog2(DIVD_W);

  // Square root unit
  localparam int ROOT_W     = 12;
  localparam int ROOT_IN_W  = 2 * ROOT_W;
  localparam int ROOT_CNT_W = $clog2(ROOT_W);

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [WLEN_W-1:0] WLEN_RST = 13'd1024;
  localparam logic [RATE_W-1:0] RATE_RST = 20'd10000;

  typedef enum logic {
    REG_WLEN = 1'b0,
    REG_RATE = 1'b1
  } wss_reg_t;

  // Snapshot of one closed window
  typedef struct packed {
    logic [SQ_W-1:0]     sq_sum;
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] peak;
    logic [CROSS_W-1:0]  crossings;
    logic [CNT_W-1:0]    count;
  } win_stats_t;

  // Request into the shared divider
  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_FREQ_GO,
    ST_FREQ_WAIT,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_EMIT
  } wss_state_t;

endpackage

>>> sv/wss_accum.sv
// wss_accum: per-sample accumulation of square sum, sum, peak and crossings.
// Depends on wss_pkg; snapshots the totals when a window closes.
module wss_accum (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          take,
  input  logic [wss_pkg::SAMPLE_W-1:0]  sample,
  input  logic [wss_pkg::WLEN_W-1:0]    window_length,
  output logic                          closing,
  output wss_pkg::win_stats_t           stats
);
  import wss_pkg::*;

  logic [CNT_W-1:0]      seen_r, seen_nxt;
  logic [SQ_W-1:0]       sq_sum_r, sq_sum_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [SAMPLE_W-1:0]   max_r, max_nxt;
  logic                  prev_low_r, is_low;
  logic [CROSS_W-1:0]    cross_r, cross_nxt;
  logic [SAMPLE_W-1:0]   dev;
  logic [2*SAMPLE_W-1:0] sq;
  logic [WLEN_W-1:0]     len_eff;
  win_stats_t            stats_r;

  // Deviation from mid-code and its square
  always_comb begin
    if (sample[SAMPLE_W-1]) begin
      dev = sample - MID_CODE;
    end else begin
      dev = MID_CODE - sample;
    end
  end
  assign sq = dev * dev;

  // Next accumulator values
  always_comb begin
    sq_sum_nxt = sq_sum_r + SQ_W'(sq);
    sum_nxt    = sum_r + SUM_W'(sample);
    max_nxt    = (sample > max_r) ? sample : max_r;
    is_low     = !sample[SAMPLE_W-1];
    cross_nxt  = cross_r;
    if ((seen_r != '0) && (is_low != prev_low_r) && (cross_r != CROSS_MAX)) begin
      cross_nxt = cross_r + 1'b1;
    end
    seen_nxt = seen_r + 1'b1;
  end

  // Effective window length: zero means one, clamp to maximum
  always_comb begin
    if (window_length == '0) begin
      len_eff = WLEN_W'(1);
    end else if (window_length > MAX_WIN) begin
      len_eff = MAX_WIN;
    end else begin
      len_eff = window_length;
    end
  end

  assign closing = (seen_nxt >= len_eff);

  // Running state; cleared when the window closes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      sq_sum_r   <= '0;
      sum_r      <= '0;
      max_r      <= '0;
      prev_low_r <= 1'b0;
      cross_r    <= '0;
    end else if (take) begin
      if (closing) begin
        seen_r     <= '0;
        sq_sum_r   <= '0;
        sum_r      <= '0;
        max_r      <= '0;
        prev_low_r <= 1'b0;
        cross_r    <= '0;
      end else begin
        seen_r     <= seen_nxt;
        sq_sum_r   <= sq_sum_nxt;
        sum_r      <= sum_nxt;
        max_r      <= max_nxt;
        prev_low_r <= is_low;
        cross_r    <= cross_nxt;
      end
    end
  end

  // Window snapshot, held while the result is worked out
  always_ff @(posedge clk) begin
    if (take && closing) begin
      stats_r.sq_sum    <= sq_sum_nxt;
      stats_r.sum       <= sum_nxt;
      stats_r.peak      <= max_nxt;
      stats_r.crossings <= cross_nxt;
      stats_r.count     <= seen_nxt;
    end
  end

  assign stats = stats_r;

endmodule

>>> sv/wss_div.sv
// wss_div: shared restoring divider, one quotient bit per cycle.
// Depends on wss_pkg; used for mean square, mean and frequency.
module wss_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wss_pkg::div_req_t           req,
  output logic                        busy,
  output logic                        done,
  output logic [wss_pkg::DIVD_W-1:0]  quotient
);
  import wss_pkg::*;

  logic                 busy_r, done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIVS_W-1:0]    dvs_r;
  logic [DIVS_W-1:0]    rem_r, rem_nxt;
  logic [DIVD_W-1:0]    quo_r;
  logic [DIVS_W:0]      shifted;
  logic                 ge;

  // One compare-subtract step
  always_comb begin
    shifted = {rem_r, quo_r[DIVD_W-1]};
    ge      = (shifted >= {1'b0, dvs_r});
    if (ge) begin
      rem_nxt = DIVS_W'(shifted - {1'b0, dvs_r});
    end else begin
      rem_nxt = DIVS_W'(shifted);
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvs_r <= req.divisor;
      rem_r <= '0;
      quo_r <= req.dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIVD_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> sv/wss_isqrt.sv
// wss_isqrt: digit-by-digit integer square root, one root bit per cycle.
// Depends on wss_pkg.
module wss_isqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [wss_pkg::ROOT_IN_W-1:0]  radicand,
  output logic                           done,
  output logic [wss_pkg::ROOT_W-1:0]     root
);
  import wss_pkg::*;

  logic                  busy_r, done_r;
  logic [ROOT_CNT_W-1:0] cnt_r;
  logic [ROOT_IN_W-1:0]  rad_r;
  logic [ROOT_W-1:0]     root_r;
  logic [ROOT_W+1:0]     rem_r, rem_nxt;
  logic [ROOT_W+3:0]     shifted, trial;
  logic                  ge;

  // Bring down two radicand bits, try root*4+1
  always_comb begin
    shifted = {rem_r, rad_r[ROOT_IN_W-1 -: 2]};
    trial   = {2'b00, root_r, 2'b01};
    ge      = (shifted >= trial);
    if (ge) begin
      rem_nxt = (ROOT_W + 2)'(shifted - trial);
    end else begin
      rem_nxt = (ROOT_W + 2)'(shifted);
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ROOT_CNT_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[ROOT_IN_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> sv/window_signal_statistics.sv
// window_signal_statistics: top level; samples stream in at one per cycle within a window.
// A window close runs three divides in turn on the shared 35-step divider, then the square root,
// then the emit; no sample is taken during that time.
// Result waits in an output register; the next window's samples are taken once it is loaded.
// Reset (rst_n low, synchronous): accumulators and control cleared, window_length 1024,
// sample_rate_hz 10000. Depends on wss_pkg, wss_accum, wss_div, wss_isqrt.
module window_signal_statistics (
  input  logic                       clk,
  input  logic                       rst_n,
  // Sample stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [15:0]                in_tdata,   // [11:0] sample
  // Result stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [71:0]                out_tdata,  // [11:0] rms, [23:12] peak, [35:24] mean,
                                                 // [47:36] crossings, [66:48] frequency_hz
  // Configuration
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [wss_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [wss_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [wss_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import wss_pkg::*;

  wss_state_t          state_r, state_nxt;
  logic [WLEN_W-1:0]   wlen_r;
  logic [RATE_W-1:0]   rate_r;
  logic                cfg_wr;
  wss_reg_t            cfg_sel;
  logic                take, win_close;
  win_stats_t          stats;
  div_req_t            div_req;
  logic                div_busy, div_done;
  logic [DIVD_W-1:0]   div_quo;
  logic                root_start, root_done;
  logic [ROOT_W-1:0]   root;
  logic [PROD_W-1:0]   prod, prod_r;
  logic [ROOT_IN_W-1:0] msq_r;
  logic [SAMPLE_W-1:0] mean_r;
  logic [FREQ_W-1:0]   freq_r;
  logic                emit_load;
  logic                out_tvalid_r;
  logic [71:0]         out_tdata_r;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_sel    = wss_reg_t'(cfg_paddr[CFG_AW-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= WLEN_RST;
      rate_r <= RATE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_WLEN: wlen_r <= cfg_pwdata[WLEN_W-1:0];
        REG_RATE: rate_r <= cfg_pwdata[RATE_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_WLEN: cfg_prdata = CFG_DW'(wlen_r);
      REG_RATE: cfg_prdata = CFG_DW'(rate_r);
      default:  cfg_prdata = '0;
    endcase
  end

  // Sample accumulation
  assign in_tready = (state_r == ST_IDLE);
  assign take      = in_tvalid & in_tready;

  wss_accum u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .sample        (in_tdata[SAMPLE_W-1:0]),
    .window_length (wlen_r),
    .closing       (win_close),
    .stats         (stats)
  );

  // Shared divider and root unit
  wss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  wss_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (msq_r),
    .done     (root_done),
    .root     (root)
  );

  // Crossings times rate, registered ahead of the frequency divide
  assign prod = stats.crossings * rate_r;

  always_ff @(posedge clk) begin
    prod_r <= prod;
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign emit_load = (state_r == ST_EMIT) && (!out_tvalid_r || out_tready);

  // Sequencer next state and unit requests
  always_comb begin
    state_nxt        = state_r;
    div_req.start    = 1'b0;
    div_req.dividend = stats.sq_sum;
    div_req.divisor  = {1'b0, stats.count};
    root_start       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (take && win_close) state_nxt = ST_SQ_GO;
      end
      ST_SQ_GO: begin
        div_req.start = 1'b1;
        state_nxt     = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (div_done) state_nxt = ST_MEAN_GO;
      end
      ST_MEAN_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIVD_W'(stats.sum);
        state_nxt        = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (div_done) state_nxt = ST_FREQ_GO;
      end
      ST_FREQ_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIVD_W'(prod_r);
        div_req.divisor  = {stats.count, 1'b0};
        state_nxt        = ST_FREQ_WAIT;
      end
      ST_FREQ_WAIT: begin
        if (div_done) state_nxt = ST_ROOT_GO;
      end
      ST_ROOT_GO: begin
        root_start = 1'b1;
        state_nxt  = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (root_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Capture quotients as each divide finishes
  always_ff @(posedge clk) begin
    if (div_done) begin
      unique case (state_r)
        ST_SQ_WAIT:   msq_r  <= div_quo[ROOT_IN_W-1:0];
        ST_MEAN_WAIT: mean_r <= div_quo[SAMPLE_W-1:0];
        ST_FREQ_WAIT: freq_r <= div_quo[FREQ_W-1:0];
        default:      ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (emit_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_tdata_r <= {5'b0, freq_r, stats.crossings, mean_r, stats.peak, root};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Checks
  a_close_starts_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (take && win_close) |=> (state_r == ST_SQ_GO))
    else $error("closing sample did not start result sequence");

  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_busy)
    else $error("divider restarted while busy");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_SQ_WAIT || state_r == ST_MEAN_WAIT ||
                  state_r == ST_FREQ_WAIT))
    else $error("divider finished outside a wait state");

  a_root_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> (state_r == ST_ROOT_WAIT))
    else $error("root finished outside its wait state");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_EMIT))
    else $error("result raised outside emit");

endmodule
